@@ hdl/ltc_pkg.sv @@
// Shared constants, opcodes and controller/datapath interface types for the cascade block.
package ltc_pkg;

  localparam int NODES          = 512;
  localparam int SLOTS_PER_NODE = 16;

  localparam int NODE_W  = 9;
  localparam int VALUE_W = 18;
  localparam int PRESS_W = 20;
  localparam int CNT_W   = 10;
  localparam int DEG_W   = $clog2(SLOTS_PER_NODE + 1);
  localparam int NBR_AW  = $clog2(NODES * SLOTS_PER_NODE);
  localparam int NBR_W   = NODE_W + VALUE_W;
  localparam int AP_W    = PRESS_W + 1;

  localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_THR   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SEED  = 2'd3
  } opcode_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch_in;
    logic clr_sweep;
    logic clr_all;
    logic edge_rd_a;
    logic edge_rd_b;
    logic edge_wr_a;
    logic edge_wr_b;
    logic thr_wr;
    logic seed_start;
    logic seed_mark;
    logic pop;
    logic fetch_deg;
    logic load_deg;
    logic node_rd;
    logic node_upd;
    logic finish;
    logic load_result;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic edge_fail;
    logic seed_oob;
    logic queue_empty;
    logic list_done;
  } stat_t;

endpackage

@@ hdl/ltc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ltc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ltc_ctrl.sv @@
// Sequencer for edge loads, threshold loads, clears and seed cascades.
module ltc_ctrl import ltc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] opcode_i,
  input  logic       out_ready_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       in_ready_o,
  output logic       out_valid_o
);

  typedef enum logic [4:0] {
    ST_RST, ST_IDLE, ST_E0, ST_E1, ST_E2, ST_E3, ST_THR, ST_CLR,
    ST_S0, ST_S1, ST_POP, ST_P1, ST_P2, ST_NB0, ST_NB1, ST_NB2, ST_FIN, ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Command decode
  always_comb begin
    cmd_o             = '0;
    cmd_o.latch_in    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.clr_all     = (state_q == ST_RST);
    cmd_o.clr_sweep   = (state_q == ST_RST) || (state_q == ST_CLR);
    cmd_o.edge_rd_a   = (state_q == ST_E0);
    cmd_o.edge_rd_b   = (state_q == ST_E1);
    cmd_o.edge_wr_a   = (state_q == ST_E2) && !stat_i.edge_fail;
    cmd_o.edge_wr_b   = (state_q == ST_E3);
    cmd_o.thr_wr      = (state_q == ST_THR);
    cmd_o.seed_start  = (state_q == ST_S0);
    cmd_o.seed_mark   = (state_q == ST_S1);
    cmd_o.pop         = (state_q == ST_POP) && !stat_i.queue_empty;
    cmd_o.fetch_deg   = (state_q == ST_P1);
    cmd_o.load_deg    = (state_q == ST_P2);
    cmd_o.node_rd     = (state_q == ST_NB1);
    cmd_o.node_upd    = (state_q == ST_NB2);
    cmd_o.finish      = (state_q == ST_FIN);
    cmd_o.load_result = (state_q == ST_DONE) && slot_free;
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RST;
      out_valid_q <= 1'b0;
    end else begin
      // New result replaces the one leaving in the same cycle
      if ((state_q == ST_DONE) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_RST: begin
          if (stat_i.clr_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            case (opcode_e'(opcode_i))
              OP_EDGE:  state_q <= ST_E0;
              OP_THR:   state_q <= ST_THR;
              OP_CLEAR: state_q <= ST_CLR;
              OP_SEED:  state_q <= ST_S0;
              default:  state_q <= ST_DONE;
            endcase
          end
        end
        ST_E0:  state_q <= ST_E1;
        ST_E1:  state_q <= ST_E2;
        ST_E2:  state_q <= stat_i.edge_fail ? ST_DONE : ST_E3;
        ST_E3:  state_q <= ST_DONE;
        ST_THR: state_q <= ST_DONE;
        ST_CLR: begin
          if (stat_i.clr_last) state_q <= ST_DONE;
        end
        ST_S0:  state_q <= stat_i.seed_oob ? ST_FIN : ST_S1;
        ST_S1:  state_q <= ST_POP;
        ST_POP: state_q <= stat_i.queue_empty ? ST_FIN : ST_P1;
        ST_P1:  state_q <= ST_P2;
        ST_P2:  state_q <= ST_NB0;
        ST_NB0: state_q <= stat_i.list_done ? ST_POP : ST_NB1;
        ST_NB1: state_q <= ST_NB2;
        ST_NB2: state_q <= ST_NB0;
        ST_FIN: state_q <= ST_DONE;
        ST_DONE: begin
          if (slot_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/ltc_dp.sv @@
// Datapath: graph, threshold, activation and queue memories with cascade counters.
module ltc_dp import ltc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [1:0]         opcode_i,
  input  logic [NODE_W-1:0]  node_a_i,
  input  logic [NODE_W-1:0]  node_b_i,
  input  logic [VALUE_W-1:0] value_i,
  output stat_t              stat_o,
  output logic [CNT_W-1:0]   newly_active_o,
  output logic [CNT_W-1:0]   total_active_o,
  output logic               status_o
);

  // Latched item
  logic [NODE_W-1:0]  a_q, b_q;
  logic [VALUE_W-1:0] v_q;

  // Sweep, edge and cascade registers
  logic [NODE_W-1:0]  idx_q;
  logic [DEG_W-1:0]   deg_a_q, deg_b_q, deg_q, i_q;
  logic [NODE_W-1:0]  f_q, nb_q;
  logic [VALUE_W-1:0] w_q;
  logic [CNT_W-1:0]   head_q, tail_q, cnt_q, total_q;
  logic               status_q;
  logic [CNT_W-1:0]   res_newly_q, res_total_q;
  logic               res_status_q;
  logic               e2_q;

  // Memory ports
  logic               deg_we, thr_we, ap_we, q_we, nbr_we;
  logic [NODE_W-1:0]  deg_wa, deg_ra, thr_wa, ap_wa, ap_ra, q_wa;
  logic [DEG_W-1:0]   deg_wd, deg_rd;
  logic [VALUE_W-1:0] thr_wd, thr_rd;
  logic [AP_W-1:0]    ap_wd, ap_rd;
  logic [NODE_W-1:0]  q_wd, q_rd;
  logic [NBR_AW-1:0]  nbr_wa, nbr_ra;
  logic [NBR_W-1:0]   nbr_wd, nbr_rd;

  // Edge checks
  logic               a_oob, b_oob, edge_fail;
  logic [DEG_W:0]     deg_a_plus2;
  logic [DEG_W-1:0]   deg_b_eff;

  // Pressure update
  logic [PRESS_W:0]   p_sum;
  logic [PRESS_W-1:0] p_new;
  logic               eligible, fires, q_room;

  assign a_oob       = (32'(a_q) >= NODES);
  assign b_oob       = (32'(b_q) >= NODES);
  assign deg_a_plus2 = (DEG_W+1)'(deg_a_q) + (DEG_W+1)'(2);
  assign edge_fail   = a_oob || b_oob ||
                       ((a_q == b_q) ? (32'(deg_a_plus2) > SLOTS_PER_NODE)
                                     : ((32'(deg_a_q) >= SLOTS_PER_NODE) ||
                                        (32'(deg_rd) >= SLOTS_PER_NODE)));
  assign deg_b_eff   = (a_q == b_q) ? deg_a_q + DEG_W'(1) : deg_rd;

  assign p_sum    = (PRESS_W+1)'(ap_rd[PRESS_W-1:0]) + (PRESS_W+1)'(w_q);
  assign p_new    = p_sum[PRESS_W] ? PRESS_MAX : p_sum[PRESS_W-1:0];
  assign eligible = (32'(nb_q) < NODES) && !ap_rd[PRESS_W];
  assign fires    = p_new > PRESS_W'(thr_rd);
  assign q_room   = (32'(tail_q) < NODES);

  assign stat_o.clr_last    = (idx_q == NODE_W'(NODES - 1));
  assign stat_o.edge_fail   = edge_fail;
  assign stat_o.seed_oob    = a_oob;
  assign stat_o.queue_empty = (head_q == tail_q);
  assign stat_o.list_done   = (i_q == deg_q);

  // Degree memory ports
  always_comb begin
    deg_we = cmd_i.clr_all || cmd_i.edge_wr_a || cmd_i.edge_wr_b;
    deg_wa = idx_q;
    deg_wd = '0;
    if (cmd_i.edge_wr_a) begin
      deg_wa = a_q;
      deg_wd = deg_a_q + DEG_W'(1);
    end else if (cmd_i.edge_wr_b) begin
      deg_wa = b_q;
      deg_wd = deg_b_q + DEG_W'(1);
    end
    if (cmd_i.edge_rd_a)      deg_ra = a_q;
    else if (cmd_i.edge_rd_b) deg_ra = b_q;
    else                      deg_ra = q_rd;
  end

  // Threshold memory ports
  assign thr_we = cmd_i.clr_all || cmd_i.thr_wr;
  assign thr_wa = cmd_i.thr_wr ? a_q : idx_q;
  assign thr_wd = cmd_i.thr_wr ? v_q : '0;

  // Activation mark and pressure memory ports
  always_comb begin
    ap_we = 1'b0;
    ap_wa = idx_q;
    ap_wd = '0;
    if (cmd_i.clr_sweep) begin
      ap_we = 1'b1;
    end else if (cmd_i.seed_mark) begin
      ap_we = !ap_rd[PRESS_W];
      ap_wa = a_q;
      ap_wd = {1'b1, ap_rd[PRESS_W-1:0]};
    end else if (cmd_i.node_upd) begin
      ap_we = eligible;
      ap_wa = nb_q;
      ap_wd = {fires, p_new};
    end
    ap_ra = cmd_i.seed_start ? a_q : nbr_rd[NBR_W-1 -: NODE_W];
  end

  // Work queue ports
  assign q_we = cmd_i.seed_start || (cmd_i.node_upd && eligible && fires && q_room);
  assign q_wa = cmd_i.seed_start ? '0 : tail_q[NODE_W-1:0];
  assign q_wd = cmd_i.seed_start ? a_q : nb_q;

  // Neighbor list ports
  assign nbr_we = cmd_i.edge_wr_a || cmd_i.edge_wr_b;
  assign nbr_wa = cmd_i.edge_wr_a
                ? NBR_AW'(a_q) * NBR_AW'(SLOTS_PER_NODE) + NBR_AW'(deg_a_q)
                : NBR_AW'(b_q) * NBR_AW'(SLOTS_PER_NODE) + NBR_AW'(deg_b_q);
  assign nbr_wd = cmd_i.edge_wr_a ? {b_q, v_q} : {a_q, v_q};
  assign nbr_ra = NBR_AW'(f_q) * NBR_AW'(SLOTS_PER_NODE) + NBR_AW'(i_q);

  ltc_ram #(.WIDTH(DEG_W), .DEPTH(NODES)) u_deg_ram (
    .clk_i, .we_i(deg_we), .waddr_i(deg_wa), .wdata_i(deg_wd),
    .raddr_i(deg_ra), .rdata_o(deg_rd)
  );

  ltc_ram #(.WIDTH(VALUE_W), .DEPTH(NODES)) u_thr_ram (
    .clk_i, .we_i(thr_we), .waddr_i(thr_wa), .wdata_i(thr_wd),
    .raddr_i(nbr_rd[NBR_W-1 -: NODE_W]), .rdata_o(thr_rd)
  );

  ltc_ram #(.WIDTH(AP_W), .DEPTH(NODES)) u_ap_ram (
    .clk_i, .we_i(ap_we), .waddr_i(ap_wa), .wdata_i(ap_wd),
    .raddr_i(ap_ra), .rdata_o(ap_rd)
  );

  ltc_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd),
    .raddr_i(head_q[NODE_W-1:0]), .rdata_o(q_rd)
  );

  ltc_ram #(.WIDTH(NBR_W), .DEPTH(NODES * SLOTS_PER_NODE)) u_nbr_ram (
    .clk_i, .we_i(nbr_we), .waddr_i(nbr_wa), .wdata_i(nbr_wd),
    .raddr_i(nbr_ra), .rdata_o(nbr_rd)
  );

  // Item latch and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      a_q <= node_a_i;
      b_q <= node_b_i;
      v_q <= value_i;
    end
    if (cmd_i.edge_rd_b) deg_a_q <= deg_rd;
    if (cmd_i.edge_wr_a) deg_b_q <= deg_b_eff;
    if (cmd_i.fetch_deg) f_q <= q_rd;
    if (cmd_i.load_deg)  deg_q <= deg_rd;
    if (cmd_i.node_rd) begin
      nb_q <= nbr_rd[NBR_W-1 -: NODE_W];
      w_q  <= nbr_rd[VALUE_W-1:0];
    end
  end

  // Control counters and results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      cnt_q        <= '0;
      i_q          <= '0;
      total_q      <= '0;
      status_q     <= 1'b0;
      res_newly_q  <= '0;
      res_total_q  <= '0;
      res_status_q <= 1'b0;
    end else begin
      if (cmd_i.latch_in) begin
        idx_q    <= '0;
        cnt_q    <= '0;
        status_q <= 1'b0;
        if (opcode_e'(opcode_i) == OP_CLEAR) total_q <= '0;
      end
      if (cmd_i.clr_sweep) idx_q <= idx_q + NODE_W'(1);
      if (cmd_i.seed_start) begin
        head_q <= '0;
        tail_q <= CNT_W'(1);
      end
      if (cmd_i.seed_mark && !ap_rd[PRESS_W]) cnt_q <= CNT_W'(1);
      if (cmd_i.pop)      head_q <= head_q + CNT_W'(1);
      if (cmd_i.load_deg) i_q <= '0;
      if (cmd_i.node_upd) begin
        i_q <= i_q + DEG_W'(1);
        if (eligible && fires) begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (q_room) tail_q <= tail_q + CNT_W'(1);
        end
      end
      if (cmd_i.finish) total_q <= total_q + cnt_q;
      if (cmd_i.load_result) begin
        res_newly_q  <= cnt_q;
        res_total_q  <= total_q;
        res_status_q <= status_q;
      end
      // Edge rejection is decided once both degrees are known
      if (e2_q && edge_fail) status_q <= 1'b1;
    end
  end

  // Marks the cycle in which the second degree read returns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_q <= 1'b0;
    end else begin
      e2_q <= cmd_i.edge_rd_b;
    end
  end

  assign newly_active_o = res_newly_q;
  assign total_active_o = res_total_q;
  assign status_o       = res_status_q;

endmodule

@@ hdl/linear_threshold_cascade.sv @@
// Linear-threshold cascade engine: timing, handshakes and reset.
// After reset a sweep over all nodes clears degrees, thresholds, marks and pressure; no item is taken.
// Load edge reads both degrees, then writes both lists (no write when dropped); clear sweeps one entry/cycle.
// Seed marks the seed, then pops each queued node, reads its degree and updates each neighbor slot in turn.
// One item at a time; the next item is taken while the previous result waits at the output.
module linear_threshold_cascade import ltc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [NODE_W-1:0]  node_a_i,
  input  logic [NODE_W-1:0]  node_b_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CNT_W-1:0]   newly_active_o,
  output logic [CNT_W-1:0]   total_active_o,
  output logic               status_o
);

  cmd_t  cmd;
  stat_t stat;

  ltc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .opcode_i, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd), .in_ready_o, .out_valid_o
  );

  ltc_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .opcode_i, .node_a_i, .node_b_i, .value_i,
    .stat_o(stat), .newly_active_o, .total_active_o, .status_o
  );

endmodule

@@ hdl/ltc_checker.sv @@
// Port-level checks for the cascade engine, bound to the top level.
module ltc_checker import ltc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         opcode_i,
  input logic [NODE_W-1:0]  node_a_i,
  input logic [NODE_W-1:0]  node_b_i,
  input logic [VALUE_W-1:0] value_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [CNT_W-1:0]   newly_active_o,
  input logic [CNT_W-1:0]   total_active_o,
  input logic               status_o
);

  // A waiting result is not withdrawn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before taken");

  // A waiting input item holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable({opcode_i, node_a_i, node_b_i, value_i}))
    else $error("input item changed while waiting");

  // One item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while previous one in work");

  // A cascade never activates more nodes than are active overall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> newly_active_o <= total_active_o)
    else $error("newly active exceeds total");

  // A dropped edge reports no activations
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> newly_active_o == '0)
    else $error("dropped edge with activations");

endmodule

bind linear_threshold_cascade ltc_checker u_ltc_checker (.*);

@@ dv/tb_linear_threshold_cascade.sv @@
// Self-checking testbench for the linear-threshold cascade engine.
module tb_linear_threshold_cascade;
  import ltc_pkg::*;

  typedef struct packed {
    opcode_e            op;
    logic [NODE_W-1:0]  na;
    logic [NODE_W-1:0]  nb;
    logic [VALUE_W-1:0] val;
  } spread_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] newly;
    logic [CNT_W-1:0] total;
    logic             stat;
  } spread_res_t;

  localparam int WATCHDOG_LIMIT = 200000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         opcode_i;
  logic [NODE_W-1:0]  node_a_i;
  logic [NODE_W-1:0]  node_b_i;
  logic [VALUE_W-1:0] value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [CNT_W-1:0]   newly_active_o;
  logic [CNT_W-1:0]   total_active_o;
  logic               status_o;

  linear_threshold_cascade dut (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Predictor state: graph, thresholds, marks and pressure
  logic [NODE_W-1:0]  adj_node [NODES][SLOTS_PER_NODE];
  logic [VALUE_W-1:0] adj_wt   [NODES][SLOTS_PER_NODE];
  int                 degree   [NODES];
  logic [VALUE_W-1:0] thresh   [NODES];
  bit                 active   [NODES];
  logic [PRESS_W-1:0] press    [NODES];
  int                 act_total;

  spread_item_t pending_items[$];
  spread_res_t  expected_results[$];
  int           mismatches;
  int           sender_idle_pct;
  int           receiver_idle_pct;
  bit           hold_sender;
  int           quiet_cycles;

  // Compute the result of one item and update the predictor state
  function automatic spread_res_t predict_spread(spread_item_t it);
    spread_res_t r;
    int          q[$];
    int          f;
    int          n;
    int          cnt;
    logic [PRESS_W:0] p;
    r = '0;
    case (it.op)
      OP_EDGE: begin
        if (it.na == it.nb) r.stat = (degree[it.na] + 2 > SLOTS_PER_NODE);
        else r.stat = (degree[it.na] >= SLOTS_PER_NODE) || (degree[it.nb] >= SLOTS_PER_NODE);
        if (!r.stat) begin
          adj_node[it.na][degree[it.na]] = it.nb;
          adj_wt[it.na][degree[it.na]] = it.val;
          degree[it.na]++;
          adj_node[it.nb][degree[it.nb]] = it.na;
          adj_wt[it.nb][degree[it.nb]] = it.val;
          degree[it.nb]++;
        end
      end
      OP_THR: thresh[it.na] = it.val;
      OP_CLEAR: begin
        foreach (active[i]) begin
          active[i] = 1'b0;
          press[i] = '0;
        end
        act_total = 0;
      end
      default: begin
        cnt = 0;
        q.insert(q.size(), int'(it.na));
        if (!active[it.na]) begin
          active[it.na] = 1'b1;
          cnt++;
        end
        while (q.size() > 0) begin
          f = q.pop_front();
          for (int i = 0; i < degree[f]; i++) begin
            n = adj_node[f][i];
            if (!active[n]) begin
              p = press[n] + adj_wt[f][i];
              if (p > PRESS_MAX) p = PRESS_MAX;
              press[n] = p[PRESS_W-1:0];
              if (press[n] > {2'b00, thresh[n]}) begin
                active[n] = 1'b1;
                cnt++;
                q.insert(q.size(), n);
              end
            end
          end
        end
        act_total += cnt;
        r.newly = cnt[CNT_W-1:0];
      end
    endcase
    r.total = act_total[CNT_W-1:0];
    return r;
  endfunction

  function automatic spread_item_t mk(opcode_e op, int a, int b, int v);
    spread_item_t it;
    it.op = op;
    it.na = a[NODE_W-1:0];
    it.nb = b[NODE_W-1:0];
    it.val = v[VALUE_W-1:0];
    return it;
  endfunction

  // Append one item to the pending list
  function automatic void add_item(spread_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // Driver: presents queued items, predicts at acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      opcode_i <= '0;
      node_a_i <= '0;
      node_b_i <= '0;
      value_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.insert(expected_results.size(),
                                predict_spread({opcode_e'(opcode_i), node_a_i,
                                                node_b_i, value_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() > 0 && !hold_sender &&
            $urandom_range(99) >= sender_idle_pct) begin
          spread_item_t it;
          it = pending_items.pop_front();
          in_valid_i <= 1'b1;
          opcode_i <= it.op;
          node_a_i <= it.na;
          node_b_i <= it.nb;
          value_i <= it.val;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares results and stalls the output at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d %0d %0d",
                                         newly_active_o, total_active_o, status_o);
        end else begin
          spread_res_t e;
          e = expected_results.pop_front();
          if (e.newly !== newly_active_o || e.total !== total_active_o ||
              e.stat !== status_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp newly %0d total %0d status %0d, got %0d %0d %0d",
                       e.newly, e.total, e.stat, newly_active_o, total_active_o, status_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  // Random item: edges, seeds, thresholds and clears, mostly within a small cluster
  function automatic spread_item_t rand_item(int base);
    int k;
    int a;
    int b;
    k = $urandom_range(99);
    a = base + $urandom_range(15);
    b = base + $urandom_range(15);
    if (k < 5) a = $urandom_range(NODES - 1);
    if (k < 40) return mk(OP_EDGE, a, b, $urandom_range(1 << 17));
    if (k < 60) return mk(OP_THR, a, $urandom_range(NODES - 1),
                          ($urandom_range(3) == 0) ? $urandom_range(262143)
                                                   : $urandom_range(1 << 16));
    if (k < 65) return mk(OP_CLEAR, $urandom_range(NODES - 1),
                          $urandom_range(NODES - 1), $urandom_range(262143));
    return mk(OP_SEED, a, $urandom_range(NODES - 1), $urandom_range(262143));
  endfunction

  initial begin
    mismatches = 0;
    quiet_cycles = 0;
    hold_sender = 1'b0;
    act_total = 0;
    foreach (degree[i]) begin
      degree[i] = 0;
      thresh[i] = '0;
      active[i] = 1'b0;
      press[i] = '0;
    end
    sender_idle_pct = 9;
    receiver_idle_pct = 75;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, self loops, full lists, repeated seed
    add_item(mk(OP_SEED, 0, 0, 0));
    add_item(mk(OP_EDGE, 0, 511, 262143));
    add_item(mk(OP_THR, 511, 0, 262143));
    add_item(mk(OP_SEED, 0, 511, 262143));
    add_item(mk(OP_SEED, 0, 0, 0));
    add_item(mk(OP_EDGE, 5, 5, 1));
    for (int i = 0; i < 8; i++) add_item(mk(OP_EDGE, 7, 7, 262143));
    add_item(mk(OP_EDGE, 7, 8, 3));
    add_item(mk(OP_THR, 8, 0, 0));
    add_item(mk(OP_SEED, 7, 0, 0));
    add_item(mk(OP_CLEAR, 511, 511, 262143));
    add_item(mk(OP_THR, 0, 0, 0));
    add_item(mk(OP_SEED, 511, 0, 0));
    add_item(mk(OP_SEED, 511, 0, 0));
    add_item(mk(OP_EDGE, 300, 301, 170));
    add_item(mk(OP_SEED, 300, 0, 0));
    wait_drained();

    // Pause until drained between random batches
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        sender_idle_pct = 75;
        receiver_idle_pct = 9;
      end else if (ph == 2) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      for (int i = 0; i < 90; i++) add_item(rand_item(16 * (ph * 7 + i / 30)));
      wait_drained();
      hold_sender = 1'b1;
      repeat (20) @(posedge clk_i);
      hold_sender = 1'b0;
    end

    repeat (2000) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
